/* src/lfbg_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfbg_pkg: shared types and constants
// Command codes, controller states and the controller/datapath link.
// ---------------------------------------------------------------------------
package lfbg_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_BLINK = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_READ  = 3'd4,
        CMD_LOAD  = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_APPLY,
        ST_TSTEP,
        ST_DUTY_RD0,
        ST_DUTY_RD1,
        ST_DUTY_MUL,
        ST_DUTY_SCL,
        ST_DUTY_EMIT,
        ST_TEND
    } state_t;

    localparam logic [15:0] LEVEL_MAX = 16'hFF00;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture the input item
        logic decode;      // compute the divider operands for the item
        logic div_start;   // divider launch; not driven, the datapath starts the divider itself
        logic apply;       // write the command's effect into channel state
        logic tick_step;   // step the current channel on a tick
        logic ch_clear;    // restart the tick channel walk
        logic ch_next;     // advance to the next channel
        logic rd_lo;       // read the lower gamma entry
        logic rd_hi;       // read the upper gamma entry
        logic mul;         // interpolation multiply
        logic scale;       // 16-bit to duty scaling
        logic emit_duty;   // present a duty result
        logic emit_plain;  // present a single non-duty result
        logic emit_tend;   // present the no-change tick result
        logic last;        // mark the result as final
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic       is_tick;
        logic       need_div;
        logic       set_duty;   // immediate set, result carries a duty
        logic       div_done;
        logic       ch_changed; // current channel produced a new level
        logic       ch_is_last;
        logic       any_emitted;
        logic       more_changes; // a later channel will change on this tick
    } dp_stat_t;

endpackage

/* src/led_fade_blink_gamma_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_fade_blink_gamma_engine: LED fade, blink and gamma duty engine
// A fade or blink set makes one step division in the shared divider; an
// immediate set with a duty runs a duty lookup. A tick walks every channel,
// with a duty lookup per changed channel and one result of its own when no
// channel changes. Items are taken one at a time; busy stays high until the
// channel walk ends.
// Reset clears all channel state; the gamma RAM is undefined until loaded.
// ---------------------------------------------------------------------------
module led_fade_blink_gamma_engine #(
    parameter int CHANNELS  = 8,
    parameter int TICK_MS   = 20,
    parameter int DUTY_BITS = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           command,
    input  logic [2:0]           channel,
    input  logic [7:0]           level,
    input  logic [15:0]          time_ms,
    input  logic                 fade_blink,
    input  logic [7:0]           table_index,
    input  logic [15:0]          table_value,
    output logic                 strobe,
    output logic [2:0]           out_channel,
    output logic [DUTY_BITS-1:0] duty,
    output logic                 duty_valid,
    output logic [7:0]           level_read,
    output logic                 all_idle,
    output logic                 last
);
    import lfbg_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    lfbg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lfbg_dp #(
        .CHANNELS  (CHANNELS),
        .TICK_MS   (TICK_MS),
        .DUTY_BITS (DUTY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .channel     (channel),
        .level       (level),
        .time_ms     (time_ms),
        .fade_blink  (fade_blink),
        .table_index (table_index),
        .table_value (table_value),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_channel (out_channel),
        .duty        (duty),
        .duty_valid  (duty_valid),
        .level_read  (level_read),
        .all_idle    (all_idle),
        .last        (last),
        .strobe      (strobe)
    );

    // a final result frees the block once the channel walk is done
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> ##[0:CHANNELS] !busy)
        else $error("busy long after final result");

    // an accepted item is never answered in the cycle after it is accepted
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe)
        else $error("result too early");

    // idle flag only on a result without duty
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && all_idle |-> !duty_valid)
        else $error("idle with duty");
endmodule

/* src/lfbg_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfbg_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lfbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/lfbg_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfbg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lfbg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] dividend,
    input  logic [16:0] divisor,
    output logic [16:0] quotient,
    output logic        done
);
    logic [16:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    // shift in one dividend bit and try a subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[16:0], quo_reg[16]};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

/* src/lfbg_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfbg_ctrl: command sequencer
// Decode, then as needed division, state update, tick walk and duty lookup.
// ---------------------------------------------------------------------------
module lfbg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lfbg_pkg::dp_stat_t stat,
    output lfbg_pkg::dp_ctrl_t ctrl
);
    import lfbg_pkg::*;

    state_t state_reg, state_next;
    logic   tick_mode_reg, tick_mode_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_mode_reg <= tick_mode_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        tick_mode_next = tick_mode_reg;
        ctrl           = '0;
        busy           = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctrl.decode = 1'b1;
                if (stat.is_tick)
                begin
                    ctrl.ch_clear  = 1'b1;
                    tick_mode_next = 1'b1;
                    state_next     = ST_TSTEP;
                end
                else
                begin
                    tick_mode_next = 1'b0;
                    state_next     = stat.need_div ? ST_DIV : ST_APPLY;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                ctrl.apply = 1'b1;
                if (stat.set_duty)
                begin
                    state_next = ST_DUTY_RD0;
                end
                else
                begin
                    ctrl.emit_plain = 1'b1;
                    ctrl.last       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TSTEP:
            begin
                ctrl.tick_step = 1'b1;
                if (stat.ch_changed)
                begin
                    state_next = ST_DUTY_RD0;
                end
                else if (stat.ch_is_last)
                begin
                    state_next = ST_TEND;
                end
                else
                begin
                    ctrl.ch_next = 1'b1;
                end
            end
            ST_DUTY_RD0:
            begin
                ctrl.rd_lo = 1'b1;
                state_next = ST_DUTY_RD1;
            end
            ST_DUTY_RD1:
            begin
                ctrl.rd_hi = 1'b1;
                state_next = ST_DUTY_MUL;
            end
            ST_DUTY_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = ST_DUTY_SCL;
            end
            ST_DUTY_SCL:
            begin
                ctrl.scale = 1'b1;
                state_next = ST_DUTY_EMIT;
            end
            ST_DUTY_EMIT:
            begin
                ctrl.emit_duty = 1'b1;
                if (!tick_mode_reg)
                begin
                    ctrl.last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.ch_is_last)
                begin
                    ctrl.last  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!stat.more_changes)
                begin
                    ctrl.last = 1'b1;
                    ctrl.ch_next = 1'b1;
                    state_next = ST_TEND;
                end
                else
                begin
                    ctrl.ch_next = 1'b1;
                    state_next   = ST_TSTEP;
                end
            end
            ST_TEND:
            begin
                // walk the remaining channels so their state still steps
                if (stat.any_emitted)
                begin
                    ctrl.tick_step = 1'b1;
                    if (stat.ch_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctrl.ch_next = 1'b1;
                    end
                end
                else
                begin
                    ctrl.emit_tend = 1'b1;
                    ctrl.last      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

/* src/lfbg_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfbg_dp: channel state and duty datapath
// Per-channel fade and blink registers, gamma RAM, divider and duty scaling.
// ---------------------------------------------------------------------------
module lfbg_dp #(
    parameter int CHANNELS  = 8,
    parameter int TICK_MS   = 20,
    parameter int DUTY_BITS = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          command,
    input  logic [2:0]          channel,
    input  logic [7:0]          level,
    input  logic [15:0]         time_ms,
    input  logic                fade_blink,
    input  logic [7:0]          table_index,
    input  logic [15:0]         table_value,
    input  lfbg_pkg::dp_ctrl_t  ctrl,
    output lfbg_pkg::dp_stat_t  stat,
    output logic [2:0]          out_channel,
    output logic [DUTY_BITS-1:0] duty,
    output logic                duty_valid,
    output logic [7:0]          level_read,
    output logic                all_idle,
    output logic                last,
    output logic                strobe
);
    import lfbg_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
    // ceil(2^32 / TICK_MS): exact floor division for any 16-bit time
    localparam logic [32:0] TICK_RECIP =
        33'(((64'd1 << 32) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

    // item registers
    logic [2:0]  cmd_reg;
    logic [2:0]  ich_reg;
    logic [7:0]  lvl_reg;
    logic [15:0] tms_reg;
    logic        fb_reg;
    logic [7:0]  tix_reg;
    logic [15:0] tval_reg;

    // channel state
    logic [15:0] level_q8_reg  [CHANNELS];
    logic [15:0] target_q8_reg [CHANNELS];
    logic [16:0] step_q8_reg   [CHANNELS];
    logic [15:0] half_reg      [CHANNELS];
    logic [15:0] left_reg      [CHANNELS];

    logic [CW-1:0] ch_reg;
    logic          emitted_reg;
    logic [3:0]    dphase_reg;   // 1: start step division, 2: dividing, 3: quotient ready
    logic [15:0]   ticks_reg;
    logic [16:0]   mag_reg;
    logic          neg_reg;
    logic [15:0]   duty_lvl_reg;
    logic [2:0]    duty_ch_reg;

    logic        ok;
    logic [CW-1:0] ich;
    assign ich = ich_reg[CW-1:0];
    assign ok  = ({1'b0, ich_reg} < 4'(CHANNELS));

    // divider
    logic        div_start;
    logic [16:0] div_a, div_b, div_q;
    logic        div_done;
    lfbg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    // gamma RAM
    logic [7:0]  ram_raddr;
    logic [15:0] ram_rdata;
    lfbg_ram #(.WIDTH(16), .DEPTH(256)) u_gamma (
        .clk   (clk),
        .we    (ctrl.load_item && (command == CMD_LOAD)),
        .waddr (table_index),
        .wdata (table_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // capture the item
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg  <= command;
            ich_reg  <= channel;
            lvl_reg  <= level;
            tms_reg  <= time_ms;
            fb_reg   <= fade_blink;
            tix_reg  <= table_index;
            tval_reg <= table_value;
        end
    end

    // decode: which commands need the divider
    logic is_set_fade, is_blink;
    assign is_set_fade = (cmd_reg == CMD_SET) && ok && (tms_reg != 16'd0);
    assign is_blink    = (cmd_reg == CMD_BLINK) && ok;

    // step magnitude and direction for a fade
    logic [16:0] set_diff_mag;
    logic        set_neg;
    logic [15:0] cur_lvl;
    assign cur_lvl = level_q8_reg[ich];
    always_comb
    begin
        if ({lvl_reg, 8'd0} >= cur_lvl)
        begin
            set_diff_mag = {1'b0, {lvl_reg, 8'd0} - cur_lvl};
            set_neg      = 1'b0;
        end
        else
        begin
            set_diff_mag = {1'b0, cur_lvl - {lvl_reg, 8'd0}};
            set_neg      = 1'b1;
        end
    end

    // tick count by reciprocal multiply, at least one tick
    logic [15:0] tick_num;
    logic [47:0] tick_prod;
    logic [15:0] tick_quo;
    logic [15:0] ticks_val;
    assign tick_num  = is_blink ? {1'b0, tms_reg[15:1]} : tms_reg;
    assign tick_prod = 48'(tick_num) * 48'(TICK_RECIP);
    assign tick_quo  = tick_prod[47:32];
    assign ticks_val = (tick_quo == 16'd0) ? 16'd1 : tick_quo;

    // one division for the step: magnitude over ticks
    assign div_start = (dphase_reg == 4'd1);
    assign div_a     = mag_reg;
    assign div_b     = {1'b0, ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dphase_reg <= '0;
        end
        else if (ctrl.decode && (is_set_fade || is_blink))
        begin
            dphase_reg <= 4'd1;
        end
        else if (dphase_reg == 4'd1)
        begin
            dphase_reg <= 4'd2;
        end
        else if (dphase_reg == 4'd2 && div_done)
        begin
            dphase_reg <= 4'd3;
        end
        else if (ctrl.apply)
        begin
            dphase_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.decode)
        begin
            mag_reg   <= is_blink ? {1'b0, lvl_reg, 8'd0} : set_diff_mag;
            neg_reg   <= is_blink ? 1'b1 : set_neg;
            ticks_reg <= ticks_val;
        end
    end

    // status to the controller
    logic [15:0] cl, ct, ch, ctl;
    logic [16:0] cs;
    logic        cloop, cneg, cstepnz;
    assign cl  = level_q8_reg[ch_reg];
    assign ct  = target_q8_reg[ch_reg];
    assign cs  = step_q8_reg[ch_reg];
    assign ch  = half_reg[ch_reg];
    assign ctl = left_reg[ch_reg];
    assign cloop   = (ch != 16'd0);
    assign cneg    = cs[16];
    assign cstepnz = (cs != 17'd0);

    logic changed;
    assign changed = (ctl != 16'd0) ? (cstepnz || !cloop) : cloop;

    // look ahead: does any later channel change on this tick
    logic more;
    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (CW'(i) > ch_reg)
            begin
                if (left_reg[i] != 16'd0)
                begin
                    if ((step_q8_reg[i] != 17'd0) || (half_reg[i] == 16'd0))
                    begin
                        more = 1'b1;
                    end
                end
                else if (half_reg[i] != 16'd0)
                begin
                    more = 1'b1;
                end
            end
        end
    end

    logic any_busy;
    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (left_reg[i] != 16'd0 || half_reg[i] != 16'd0)
            begin
                any_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.is_tick      = (cmd_reg == CMD_TICK);
        stat.need_div     = is_set_fade || is_blink;
        stat.set_duty     = (cmd_reg == CMD_SET) && ok && (tms_reg == 16'd0);
        stat.div_done     = (dphase_reg == 4'd2) && div_done;
        stat.ch_changed   = changed;
        stat.ch_is_last   = ({1'b0, ch_reg} == (CW+1)'(CHANNELS - 1));
        stat.any_emitted  = emitted_reg;
        stat.more_changes = more;
    end

    // tick step arithmetic for the current channel
    logic [15:0] left_dec;
    logic [17:0] sum;
    logic [15:0] sum_cl;
    logic [16:0] neg_s;
    logic [15:0] new_lvl;
    logic [16:0] new_step;
    logic [15:0] new_left;
    assign left_dec = ctl - 16'd1;
    assign neg_s    = 17'd0 - cs;
    always_comb
    begin
        new_step = cs;
        new_left = ctl;
        new_lvl  = cl;
        sum      = '0;
        if (ctl != 16'd0)
        begin
            new_left = left_dec;
            sum      = {2'b0, cl} + {cs[16], cs};
            if (cstepnz)
            begin
                if (left_dec != 16'd0)
                begin
                    new_lvl = sum_cl;
                end
                else if (cloop && cneg)
                begin
                    new_lvl = 16'd0;
                end
                else
                begin
                    new_lvl = ct;
                end
            end
            else if (!cloop)
            begin
                new_lvl = ct;
            end
        end
        else if (cloop)
        begin
            new_left = ch;
            if (cstepnz)
            begin
                new_step = neg_s;
                sum      = {2'b0, cl} + {neg_s[16], neg_s};
                new_lvl  = sum_cl;
            end
            else
            begin
                new_lvl = (cl == ct) ? 16'd0 : ct;
            end
        end
    end
    assign sum_cl = sum[17] ? 16'd0 : ((sum[16:0] > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[15:0]);

    // channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_q8_reg[i]  <= '0;
                target_q8_reg[i] <= '0;
                step_q8_reg[i]   <= '0;
                half_reg[i]      <= '0;
                left_reg[i]      <= '0;
            end
        end
        else if (ctrl.tick_step)
        begin
            level_q8_reg[ch_reg] <= new_lvl;
            step_q8_reg[ch_reg]  <= new_step;
            left_reg[ch_reg]     <= new_left;
        end
        else if (ctrl.apply && ok)
        begin
            unique case (cmd_reg)
                CMD_SET:
                begin
                    target_q8_reg[ich] <= {lvl_reg, 8'd0};
                    half_reg[ich]      <= '0;
                    if (tms_reg == 16'd0)
                    begin
                        level_q8_reg[ich] <= {lvl_reg, 8'd0};
                        left_reg[ich]     <= '0;
                        step_q8_reg[ich]  <= '0;
                    end
                    else
                    begin
                        left_reg[ich]    <= ticks_reg;
                        step_q8_reg[ich] <= neg_reg ? (17'd0 - div_q) : div_q;
                    end
                end
                CMD_BLINK:
                begin
                    target_q8_reg[ich] <= {lvl_reg, 8'd0};
                    level_q8_reg[ich]  <= {lvl_reg, 8'd0};
                    half_reg[ich]      <= ticks_reg;
                    if (fb_reg)
                    begin
                        left_reg[ich]    <= ticks_reg;
                        step_q8_reg[ich] <= 17'd0 - div_q;
                    end
                    else
                    begin
                        left_reg[ich]    <= '0;
                        step_q8_reg[ich] <= '0;
                    end
                end
                CMD_STOP:
                begin
                    half_reg[ich]    <= '0;
                    left_reg[ich]    <= '0;
                    step_q8_reg[ich] <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // channel walk and duty source
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg      <= '0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.ch_clear)
            begin
                ch_reg      <= '0;
                emitted_reg <= 1'b0;
            end
            else if (ctrl.ch_next && !stat.ch_is_last)
            begin
                ch_reg <= ch_reg + CW'(1);
            end
            if (ctrl.emit_duty)
            begin
                emitted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tick_step)
        begin
            duty_lvl_reg <= new_lvl;
            duty_ch_reg  <= 3'(ch_reg);
        end
        else if (ctrl.apply)
        begin
            duty_lvl_reg <= {lvl_reg, 8'd0};
            duty_ch_reg  <= ich_reg;
        end
    end

    // duty: read two entries, scale each, interpolate
    logic [7:0]  idx;
    logic [15:0] g_lo_reg, g_hi_reg;
    logic [DUTY_BITS-1:0] s_lo_reg, s_hi_reg;
    logic [DUTY_BITS+8:0] part_reg;
    assign idx = duty_lvl_reg[15:8];
    assign ram_raddr = ctrl.rd_hi ? ((idx == 8'hFF) ? idx : idx + 8'd1) : idx;

    // scale 16-bit gamma to duty: floor(g * DMAX / 65535)
    function automatic logic [DUTY_BITS-1:0] scale16(input logic [15:0] g);
        logic [31:0] p;
        logic [32:0] t;
        logic [15:0] q;
        begin
            p = 32'(g) * 32'(DUTY_MAX);
            // q = floor(p / 65535) via p + p>>16 + 1 approximations
            t = 33'(p) + 33'(p >> 16) + 33'd1;
            q = t[31:16];
            scale16 = q[DUTY_BITS-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_hi)
        begin
            g_lo_reg <= ram_rdata;
        end
        if (ctrl.mul)
        begin
            g_hi_reg <= ram_rdata;
            s_lo_reg <= scale16(g_lo_reg);
        end
        if (ctrl.scale)
        begin
            s_hi_reg <= scale16(g_hi_reg);
        end
    end

    // interpolate: lo + trunc((hi - lo) * frac / 256)
    logic signed [DUTY_BITS+1:0] dlt;
    logic signed [DUTY_BITS+9:0] prod;
    logic        [DUTY_BITS+9:0] pmag;
    logic signed [DUTY_BITS+9:0] dsum;
    logic [DUTY_BITS-1:0] duty_val;
    assign dlt  = $signed({2'b0, s_hi_reg}) - $signed({2'b0, s_lo_reg});
    assign prod = dlt * $signed({1'b0, duty_lvl_reg[7:0]});
    always_comb
    begin
        pmag = prod[DUTY_BITS+9] ? (~prod + 1'b1) : prod;
        pmag = pmag >> 8;
        if (prod[DUTY_BITS+9])
        begin
            dsum = $signed({10'b0, s_lo_reg}) - $signed(pmag);
        end
        else
        begin
            dsum = $signed({10'b0, s_lo_reg}) + $signed(pmag);
        end
        if (dsum < 0)
        begin
            duty_val = '0;
        end
        else if (dsum > $signed({10'b0, DUTY_MAX}))
        begin
            duty_val = DUTY_MAX;
        end
        else
        begin
            duty_val = dsum[DUTY_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe      <= 1'b0;
            out_channel <= '0;
            duty        <= '0;
            duty_valid  <= 1'b0;
            level_read  <= '0;
            all_idle    <= 1'b0;
            last        <= 1'b0;
        end
        else
        begin
            strobe      <= ctrl.emit_duty || ctrl.emit_plain || ctrl.emit_tend;
            last        <= ctrl.last;
            out_channel <= '0;
            duty        <= '0;
            duty_valid  <= 1'b0;
            level_read  <= '0;
            all_idle    <= 1'b0;
            if (ctrl.emit_duty)
            begin
                out_channel <= duty_ch_reg;
                duty        <= duty_val;
                duty_valid  <= 1'b1;
            end
            else if (ctrl.emit_tend)
            begin
                all_idle <= !any_busy;
            end
            else if (ctrl.emit_plain)
            begin
                out_channel <= (cmd_reg > CMD_LOAD) ? 3'd0 : ich_reg;
                if (cmd_reg == CMD_READ && ok)
                begin
                    level_read <= (cur_lvl > LEVEL_MAX) ? 8'hFF : cur_lvl[15:8];
                end
            end
        end
    end

    logic unused;
    assign unused = ^{tix_reg, tval_reg, ctrl.div_start, ctrl.last, tick_prod[31:0]};
endmodule

/* test/tb_led_fade_blink_gamma_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_led_fade_blink_gamma_engine: self-checking bench for the LED engine
// Loads the gamma table, runs directed fade/blink/read cases and then
// random command mixes under bursty start traffic. A behavioral model
// predicts every result and a monitor compares each strobed result in order.
// ---------------------------------------------------------------------------
module tb_led_fade_blink_gamma_engine;
    import lfbg_pkg::*;

    localparam int          NCH        = 8;
    localparam int          TICK_MS    = 20;
    localparam int          DUTY_TOP   = 8191;
    localparam int          IDLE_LIMIT = 20000;
    localparam logic [2:0]  CMD_RSVD_A = 3'd6;
    localparam logic [2:0]  CMD_RSVD_B = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  ch;
        logic [7:0]  lvl;
        logic [15:0] tms;
        logic        fb;
        logic [7:0]  tix;
        logic [15:0] tval;
        bit          drain;
    } item_t;

    typedef struct {
        logic [2:0]  ch;
        logic [12:0] duty;
        logic        dv;
        logic [7:0]  lvl;
        logic        idle;
        logic        last;
    } led_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] command = '0;
    logic [2:0] channel = '0;
    logic [7:0] level = '0;
    logic [15:0] time_ms = '0;
    logic fade_blink = 1'b0;
    logic [7:0] table_index = '0;
    logic [15:0] table_value = '0;
    logic strobe;
    logic [2:0] out_channel;
    logic [12:0] duty;
    logic duty_valid;
    logic [7:0] level_read;
    logic all_idle;
    logic last;

    item_t       pending_items[$];
    led_result_t expected_results[$];
    item_t       cur_item;
    int          errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          quiet_cycles = 0;

    // model state per channel
    int          lvl_q8[NCH];
    int          tgt_q8[NCH];
    int          step_q8[NCH];
    int          blink_half[NCH];
    int          ticks_left[NCH];
    logic [15:0] gamma_mem[256];

    led_fade_blink_gamma_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .channel(channel), .level(level), .time_ms(time_ms),
        .fade_blink(fade_blink), .table_index(table_index),
        .table_value(table_value), .strobe(strobe), .out_channel(out_channel),
        .duty(duty), .duty_valid(duty_valid), .level_read(level_read),
        .all_idle(all_idle), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // wrap a step into 17-bit two's complement
    function automatic int wrap17(int s);
        int v;
        v = s & 'h1FFFF;
        return (v & 'hFFFF) - (v & 'h10000);
    endfunction

    function automatic int clamp_q8(int v);
        if (v < 0)
            return 0;
        if (v > 65280)
            return 65280;
        return v;
    endfunction

    function automatic longint gamma_scaled(logic [15:0] g);
        return (longint'(g) * DUTY_TOP) / 65535;
    endfunction

    // interpolate the gamma table at a Q8 level
    function automatic logic [12:0] duty_of_level(int q8);
        int     idx;
        int     frac;
        longint lo;
        longint hi;
        longint prod;
        longint d;
        idx = (q8 >> 8) & 255;
        frac = q8 & 255;
        lo = gamma_scaled(gamma_mem[idx]);
        hi = (idx < 255) ? gamma_scaled(gamma_mem[idx + 1]) : lo;
        prod = (hi - lo) * frac;
        d = lo + ((prod < 0) ? -((-prod) / 256) : (prod / 256));
        if (d < 0)
            d = 0;
        if (d > DUTY_TOP)
            d = DUTY_TOP;
        return d[12:0];
    endfunction

    function automatic led_result_t mk_result(int ch, logic [12:0] d, logic dv,
                                              int lv, logic idle);
        led_result_t r;
        r.ch = ch[2:0];
        r.duty = d;
        r.dv = dv;
        r.lvl = lv[7:0];
        r.idle = idle;
        r.last = 1'b0;
        return r;
    endfunction

    // advance every channel by one tick and collect duty changes
    task automatic predict_tick(ref led_result_t res[$]);
        int  idle_cnt;
        int  s;
        bit  loop_on;
        idle_cnt = 0;
        for (int c = 0; c < NCH; c++)
        begin
            loop_on = blink_half[c] != 0;
            s = step_q8[c];
            if (ticks_left[c] > 0)
            begin
                ticks_left[c] = ticks_left[c] - 1;
                if (s != 0)
                begin
                    if (ticks_left[c] != 0)
                        lvl_q8[c] = clamp_q8(lvl_q8[c] + s);
                    else if (loop_on && s < 0)
                        lvl_q8[c] = 0;
                    else
                        lvl_q8[c] = tgt_q8[c];
                end
                else if (loop_on)
                    continue;
                else
                    lvl_q8[c] = tgt_q8[c];
                res.push_back(mk_result(c, duty_of_level(lvl_q8[c]), 1'b1, 0, 1'b0));
            end
            else if (loop_on)
            begin
                ticks_left[c] = blink_half[c];
                if (s != 0)
                begin
                    step_q8[c] = wrap17(-s);
                    lvl_q8[c] = clamp_q8(lvl_q8[c] + step_q8[c]);
                end
                else
                    lvl_q8[c] = (lvl_q8[c] == tgt_q8[c]) ? 0 : tgt_q8[c];
                res.push_back(mk_result(c, duty_of_level(lvl_q8[c]), 1'b1, 0, 1'b0));
            end
            else
                idle_cnt++;
        end
        if (res.size() == 0)
            res.push_back(mk_result(0, '0, 1'b0, 0, idle_cnt >= NCH));
    endtask

    // update the model for one accepted item and queue its results
    task automatic predict_item(item_t it);
        led_result_t res[$];
        int          c;
        int          t;
        int          diff;
        int          mag;
        int          half;
        c = it.ch;
        case (it.cmd)
            CMD_TICK:
                predict_tick(res);
            CMD_LOAD:
            begin
                gamma_mem[it.tix] = it.tval;
                res.push_back(mk_result(c, '0, 1'b0, 0, 1'b0));
            end
            CMD_SET:
            begin
                tgt_q8[c] = int'(it.lvl) << 8;
                blink_half[c] = 0;
                if (it.tms == 0)
                begin
                    lvl_q8[c] = tgt_q8[c];
                    ticks_left[c] = 0;
                    step_q8[c] = 0;
                    res.push_back(mk_result(c, duty_of_level(lvl_q8[c]), 1'b1, 0, 1'b0));
                end
                else
                begin
                    t = (it.tms < TICK_MS) ? 1 : it.tms / TICK_MS;
                    diff = tgt_q8[c] - lvl_q8[c];
                    mag = (diff < 0) ? -diff : diff;
                    ticks_left[c] = t;
                    step_q8[c] = wrap17((diff < 0) ? -(mag / t) : mag / t);
                    res.push_back(mk_result(c, '0, 1'b0, 0, 1'b0));
                end
            end
            CMD_BLINK:
            begin
                half = (it.tms / 2) / TICK_MS;
                if (half == 0)
                    half = 1;
                tgt_q8[c] = int'(it.lvl) << 8;
                lvl_q8[c] = tgt_q8[c];
                blink_half[c] = half;
                ticks_left[c] = it.fb ? half : 0;
                step_q8[c] = it.fb ? wrap17(-(lvl_q8[c] / half)) : 0;
                res.push_back(mk_result(c, '0, 1'b0, 0, 1'b0));
            end
            CMD_STOP:
            begin
                blink_half[c] = 0;
                ticks_left[c] = 0;
                step_q8[c] = 0;
                res.push_back(mk_result(c, '0, 1'b0, 0, 1'b0));
            end
            CMD_READ:
                res.push_back(mk_result(c, '0, 1'b0,
                                        ((lvl_q8[c] > 65280) ? 65280 : lvl_q8[c]) >> 8,
                                        1'b0));
            default:
                res.push_back(mk_result(0, '0, 1'b0, 0, 1'b0));
        endcase
        res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_results.push_back(res[i]);
    endtask

    // random item: every field filled so unused bits toggle too
    function automatic item_t rand_item(logic [2:0] cmd);
        item_t it;
        it.cmd = cmd;
        it.ch = 3'($urandom_range(0, 7));
        it.lvl = 8'($urandom_range(0, 255));
        it.tms = 16'($urandom_range(0, 65535));
        it.fb = 1'($urandom_range(0, 1));
        it.tix = 8'($urandom_range(0, 255));
        it.tval = 16'($urandom_range(0, 65535));
        it.drain = ($urandom_range(0, 49) == 0);
        return it;
    endfunction

    task automatic add_item(logic [2:0] cmd, int ch, int lv, int tms, bit fb);
        item_t it;
        it = rand_item(cmd);
        it.ch = ch[2:0];
        it.lvl = lv[7:0];
        it.tms = tms[15:0];
        it.fb = fb;
        it.drain = 1'b0;
        pending_items.push_back(it);
    endtask

    // mostly short times, so phases end within a few ticks; some 0, max or random
    function automatic int pick_time();
        case ($urandom_range(0, 9))
            0: return 65535;
            1: return $urandom_range(0, 65535);
            2: return 0;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // driver: accept, predict, then present the next item by burst pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && busy)
            start <= 1'b1;
        else
        begin
            if (start)
                predict_item(cur_item);
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0
                     && (!pending_items[0].drain || expected_results.size() == 0))
            begin
                cur_item = pending_items.pop_front();
                command <= cur_item.cmd;
                channel <= cur_item.ch;
                level <= cur_item.lvl;
                time_ms <= cur_item.tms;
                fade_blink <= cur_item.fb;
                table_index <= cur_item.tix;
                table_value <= cur_item.tval;
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no activity for %0d cycles", $realtime, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
            if (strobe)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result ch=%0d duty=%0d", $realtime,
                             out_channel, duty);
                    errors++;
                end
                else
                begin
                    led_result_t e;
                    e = expected_results.pop_front();
                    if (out_channel !== e.ch || duty !== e.duty || duty_valid !== e.dv
                        || level_read !== e.lvl || all_idle !== e.idle || last !== e.last)
                    begin
                        $display("%0t mismatch exp ch=%0d duty=%0d dv=%0b lvl=%0d idle=%0b last=%0b",
                                 $realtime, e.ch, e.duty, e.dv, e.lvl, e.idle, e.last);
                        $display("%0t          act ch=%0d duty=%0d dv=%0b lvl=%0d idle=%0b last=%0b",
                                 $realtime, out_channel, duty, duty_valid, level_read,
                                 all_idle, last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        int r;
        item_t it;
        for (int c = 0; c < NCH; c++)
        begin
            lvl_q8[c] = 0;
            tgt_q8[c] = 0;
            step_q8[c] = 0;
            blink_half[c] = 0;
            ticks_left[c] = 0;
        end

        // fill the gamma table first, fixed extremes at the ends and a steep mid fall
        for (int i = 0; i < 256; i++)
        begin
            it = rand_item(CMD_LOAD);
            it.tix = 8'(i);
            it.drain = 1'b0;
            if (i == 0 || i == 129)
                it.tval = 16'h0000;
            else if (i == 255 || i == 128)
                it.tval = 16'hFFFF;
            pending_items.push_back(it);
        end

        // directed cases
        add_item(CMD_TICK, 0, 0, 0, 0);
        add_item(CMD_SET, 0, 255, 0, 0);
        add_item(CMD_SET, 1, 128, 0, 1);
        add_item(CMD_SET, 1, 0, 0, 0);
        add_item(CMD_READ, 0, 0, 0, 0);
        add_item(CMD_SET, 2, 255, 19, 0);
        add_item(CMD_SET, 3, 129, 60, 0);
        add_item(CMD_SET, 0, 0, 100, 0);
        add_item(CMD_BLINK, 4, 200, 0, 0);
        add_item(CMD_BLINK, 5, 255, 100, 1);
        add_item(CMD_BLINK, 6, 0, 80, 1);
        add_item(CMD_BLINK, 7, 255, 65535, 1);
        add_item(CMD_RSVD_A, 3, 0, 0, 0);
        add_item(CMD_RSVD_B, 7, 255, 65535, 1);
        repeat (6)
            add_item(CMD_TICK, 0, 0, 0, 0);
        add_item(CMD_STOP, 4, 0, 0, 0);
        add_item(CMD_READ, 5, 0, 0, 0);
        add_item(CMD_SET, 2, 0, 65535, 0);
        add_item(CMD_TICK, 0, 0, 0, 0);
        pending_items[pending_items.size() - 1].drain = 1'b1;
        add_item(CMD_READ, 7, 0, 0, 0);

        // random mix: commands followed by runs of ticks
        n = 0;
        while (n < 129)
        begin
            r = $urandom_range(0, 19);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    pending_items.push_back(rand_item(CMD_TICK));
                    n++;
                end
                continue;
            end
            else if (r < 10)
            begin
                it = rand_item(CMD_SET);
                it.tms = 0;
            end
            else if (r < 13)
            begin
                it = rand_item(CMD_SET);
                it.tms = 16'(pick_time());
            end
            else if (r < 15)
            begin
                it = rand_item(CMD_BLINK);
                it.tms = 16'(pick_time());
            end
            else if (r == 15)
                it = rand_item(CMD_STOP);
            else if (r == 16)
                it = rand_item(CMD_READ);
            else if (r == 17)
                it = rand_item(CMD_LOAD);
            else if (r == 18)
                it = rand_item($urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B);
            else
            begin
                it = rand_item(CMD_SET);
                it.lvl = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                it.tms = 16'($urandom_range(20, 100));
            end
            pending_items.push_back(it);
            n++;
        end

        // reset
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // drain the stimulus and all expected results
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t %0d expected results never arrived", $realtime,
                     expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
src/lfbg_pkg.sv
src/lfbg_ram.sv
src/lfbg_div.sv
src/lfbg_ctrl.sv
src/lfbg_dp.sv
src/led_fade_blink_gamma_engine.sv
test/tb_led_fade_blink_gamma_engine.sv
